[hw/rtl/sha256_message_hasher_macros.svh]
// ----------------------------------------------------------------------------
// sha256 message hasher assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_HASHER_MACROS_SVH
`define SHA256_MESSAGE_HASHER_MACROS_SVH

// checked only outside reset
`define SHAMH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SHAMH_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/shamh_pkg.sv]
// ----------------------------------------------------------------------------
// shamh_pkg
// types, constants and tables of the sha-256 message hasher
// ----------------------------------------------------------------------------
`default_nettype none

package shamh_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned ROUNDS  = 64;
	localparam int unsigned BLK_BYTES = 64;
	localparam int unsigned BLK_W   = BLK_BYTES * BYTE_W;
	localparam int unsigned DIG_WORDS = 8;
	localparam int unsigned POS_W   = $clog2(BLK_BYTES);
	localparam int unsigned RND_W   = $clog2(ROUNDS);
	localparam int unsigned IDX_W   = $clog2(DIG_WORDS);
	localparam int unsigned LEN_W   = 64;

	localparam logic [BYTE_W-1:0] PAD_BYTE  = 8'h80;
	localparam logic [POS_W-1:0]  LEN_POS   = POS_W'(56);
	localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(BLK_BYTES - 1);
	localparam logic [RND_W-1:0]  RND_LAST  = RND_W'(ROUNDS - 1);
	localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(DIG_WORDS - 1);

	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		logic [WORD_W-1:0] d;
		logic [WORD_W-1:0] e;
		logic [WORD_W-1:0] f;
		logic [WORD_W-1:0] g;
		logic [WORD_W-1:0] h;
	} work_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	localparam logic [WORD_W-1:0] INIT_CHAIN [DIG_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

`default_nettype wire

[hw/rtl/shamh_round.sv]
// ----------------------------------------------------------------------------
// shamh_round
// one sha-256 round and the matching message schedule word
// ----------------------------------------------------------------------------
`default_nettype none

module shamh_round (
	input  var shamh_pkg::work_t   vars_in,
	input  wire  [31:0]            w_t,
	input  wire  [31:0]            w_t1,
	input  wire  [31:0]            w_t9,
	input  wire  [31:0]            w_t14,
	input  wire  [31:0]            k_t,
	output shamh_pkg::work_t       vars_out,
	output logic [31:0]            sched_w
);
	import shamh_pkg::*;

	function automatic logic [WORD_W-1:0] ror(input logic [WORD_W-1:0] x, input int unsigned n);
		ror = (x >> n) | (x << (WORD_W - n));
	endfunction

	logic [WORD_W-1:0] big0, big1, ch, maj, t1, t2, sig0, sig1;

	always_comb begin
		big1 = ror(vars_in.e, 6) ^ ror(vars_in.e, 11) ^ ror(vars_in.e, 25);
		ch   = (vars_in.e & vars_in.f) ^ (~vars_in.e & vars_in.g);
		t1   = vars_in.h + big1 + ch + k_t + w_t;
		big0 = ror(vars_in.a, 2) ^ ror(vars_in.a, 13) ^ ror(vars_in.a, 22);
		maj  = (vars_in.a & vars_in.b) ^ (vars_in.a & vars_in.c) ^ (vars_in.b & vars_in.c);
		t2   = big0 + maj;

		vars_out.h = vars_in.g;
		vars_out.g = vars_in.f;
		vars_out.f = vars_in.e;
		vars_out.e = vars_in.d + t1;
		vars_out.d = vars_in.c;
		vars_out.c = vars_in.b;
		vars_out.b = vars_in.a;
		vars_out.a = t1 + t2;

		// schedule word sixteen places ahead of the current one
		sig0    = ror(w_t1, 7) ^ ror(w_t1, 18) ^ (w_t1 >> 3);
		sig1    = ror(w_t14, 17) ^ ror(w_t14, 19) ^ (w_t14 >> 10);
		sched_w = w_t + sig0 + w_t9 + sig1;
	end

endmodule

`default_nettype wire

[hw/rtl/sha256_message_hasher.sv]
// ----------------------------------------------------------------------------
// sha256_message_hasher
// byte-serial sha-256 hasher with padding and digest output
// ----------------------------------------------------------------------------
// usage:
//   the slave stream carries one request per message byte; tuser[0] says the
//   byte is valid, tlast ends the message (an end request may carry no byte).
//   the master stream returns the digest as eight 32-bit words, word 0 first,
//   tuser holding the word index and tlast set on the eighth word.
// padding and rounds:
//   a byte that does not complete a block is shifted in and input stays open.
//   a byte that completes a block starts the shared round unit, which runs
//   one round per cycle for 64 rounds; a fold step then adds into the chain.
//   an end request pads from the position to the block end, then runs the
//   rounds and fold; the position counts the block's bytes including the
//   request's own byte, and a byte that completes the block first has its
//   own rounds and fold and leaves position 0; one more padded block follows
//   when fewer than 9 byte slots are left, then the eight digest words go out.
// reset clears the chain to the initial hash values, the position and the
// bit count; no pass over storage is needed.
// a stalled receiver holds the digest word in the output register; the input
// side is closed until all eight words are loaded, then reopens while the
// last word may still wait.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_message_hasher (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire  [0:0]  s_axis_tuser,   // [0] has_byte
	input  wire         s_axis_tlast,   // end_of_message
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] digest_word
	output logic [2:0]  m_axis_tuser,   // [2:0] word_index
	output logic        m_axis_tlast    // last_word
);
	import shamh_pkg::*;

	state_t state_q, state_d, ret_q, ret_d;

	logic [BLK_W-1:0]  buf_q;
	logic [POS_W-1:0]  pos_q;
	logic [LEN_W-1:0]  bitlen_q;
	logic [RND_W-1:0]  round_q;
	logic [IDX_W-1:0]  idx_q;
	logic [WORD_W-1:0] chain_q [DIG_WORDS];
	work_t             vars_q, vars_nx;
	logic [WORD_W-1:0] sched_w;

	logic              first_q, first_d;
	logic              len_ok_q, len_ok_d, len_ok_eff;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_word_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic              out_last_q;

	logic              s_accept, shift_en, count_len, start_cmp, round_go, fold;
	logic              emit_load, finish;
	logic [BYTE_W-1:0] shift_val;
	logic [BYTE_W-1:0] len_byte;

	assign s_accept = s_axis_tvalid && s_axis_tready;
	// big-endian length, byte slot 56 takes the top byte
	assign len_byte = bitlen_q[{~pos_q[2:0], 3'b000} +: BYTE_W];
	assign len_ok_eff = first_q ? (pos_q < LEN_POS) : len_ok_q;

	shamh_round u_round (
		.vars_in  (vars_q),
		.w_t      (buf_q[BLK_W-1            -: WORD_W]),
		.w_t1     (buf_q[BLK_W-1-WORD_W     -: WORD_W]),
		.w_t9     (buf_q[BLK_W-1-9*WORD_W   -: WORD_W]),
		.w_t14    (buf_q[BLK_W-1-14*WORD_W  -: WORD_W]),
		.k_t      (ROUND_K[round_q]),
		.vars_out (vars_nx),
		.sched_w  (sched_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ret_q    <= ST_IDLE;
			first_q  <= 1'b0;
			len_ok_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			ret_q    <= ret_d;
			first_q  <= first_d;
			len_ok_q <= len_ok_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		ret_d         = ret_q;
		first_d       = first_q;
		len_ok_d      = len_ok_q;
		s_axis_tready = 1'b0;
		shift_en      = 1'b0;
		shift_val     = s_axis_tdata;
		count_len     = 1'b0;
		start_cmp     = 1'b0;
		round_go      = 1'b0;
		fold          = 1'b0;
		emit_load     = 1'b0;
		finish        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_accept) begin
					first_d  = s_axis_tlast;
					len_ok_d = 1'b0;
					if (s_axis_tuser[0]) begin
						shift_en  = 1'b1;
						count_len = 1'b1;
					end
					if (s_axis_tuser[0] && pos_q == POS_LAST) begin
						start_cmp = 1'b1;
						state_d   = ST_ROUND;
						ret_d     = s_axis_tlast ? ST_PAD : ST_IDLE;
					end else if (s_axis_tlast) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				shift_en = 1'b1;
				first_d  = 1'b0;
				if (first_q) begin
					shift_val = PAD_BYTE;
				end else if (len_ok_q && pos_q >= LEN_POS) begin
					shift_val = len_byte;
				end else begin
					shift_val = '0;
				end
				len_ok_d = len_ok_eff;
				if (pos_q == POS_LAST) begin
					start_cmp = 1'b1;
					state_d   = ST_ROUND;
					// no room for the length: one more block follows
					ret_d     = len_ok_eff ? ST_EMIT : ST_PAD;
					len_ok_d  = 1'b1;
				end
			end
			ST_ROUND: begin
				round_go = 1'b1;
				if (round_q == RND_LAST) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				fold    = 1'b1;
				state_d = ret_q;
			end
			ST_EMIT: begin
				if (!out_valid_q || m_axis_tready) begin
					emit_load = 1'b1;
					if (idx_q == IDX_LAST) begin
						finish  = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// message window: bytes shift in, schedule words shift through during rounds
	always_ff @(posedge clk) begin
		if (shift_en) begin
			buf_q <= {buf_q[BLK_W-BYTE_W-1:0], shift_val};
		end else if (round_go) begin
			buf_q <= {buf_q[BLK_W-WORD_W-1:0], sched_w};
		end
	end

	always_ff @(posedge clk) begin
		if (start_cmp) begin
			vars_q <= {chain_q[0], chain_q[1], chain_q[2], chain_q[3],
			           chain_q[4], chain_q[5], chain_q[6], chain_q[7]};
		end else if (round_go) begin
			vars_q <= vars_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			bitlen_q <= '0;
			round_q  <= '0;
			idx_q    <= '0;
			for (int i = 0; i < DIG_WORDS; i++) begin
				chain_q[i] <= INIT_CHAIN[i];
			end
		end else begin
			if (shift_en) begin
				pos_q <= pos_q + POS_W'(1);
			end
			if (count_len) begin
				bitlen_q <= bitlen_q + LEN_W'(BYTE_W);
			end
			if (round_go) begin
				round_q <= round_q + RND_W'(1);
			end
			if (emit_load) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (fold) begin
				chain_q[0] <= chain_q[0] + vars_q.a;
				chain_q[1] <= chain_q[1] + vars_q.b;
				chain_q[2] <= chain_q[2] + vars_q.c;
				chain_q[3] <= chain_q[3] + vars_q.d;
				chain_q[4] <= chain_q[4] + vars_q.e;
				chain_q[5] <= chain_q[5] + vars_q.f;
				chain_q[6] <= chain_q[6] + vars_q.g;
				chain_q[7] <= chain_q[7] + vars_q.h;
			end else if (finish) begin
				bitlen_q <= '0;
				for (int i = 0; i < DIG_WORDS; i++) begin
					chain_q[i] <= INIT_CHAIN[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_word_q <= chain_q[idx_q];
			out_idx_q  <= idx_q;
			out_last_q <= (idx_q == IDX_LAST);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_word_q;
	assign m_axis_tuser  = out_idx_q;
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

[hw/rtl/shamh_checker.sv]
// ----------------------------------------------------------------------------
// shamh_checker
// port-level checks of the sha-256 message hasher, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha256_message_hasher_macros.svh"

module shamh_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire [7:0]  s_axis_tdata,
	input wire [0:0]  s_axis_tuser,
	input wire        s_axis_tlast,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [31:0] m_axis_tdata,
	input wire [2:0]  m_axis_tuser,
	input wire        m_axis_tlast
);

	// a pending digest word is never withdrawn
	`SHAMH_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "digest word dropped while stalled")

	// an end request leads into padding (after the block's rounds if its byte completes one), so input closes
	`SHAMH_ASSERT(a_end_busy, s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready, "input open right after end of message")

	// tlast marks exactly the eighth word
	`SHAMH_ASSERT(a_last_idx, m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)), "tlast does not match word index")

	// words come out in order while the digest is handed out
	`SHAMH_ASSERT(a_idx_seq, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !m_axis_tvalid || (m_axis_tuser == $past(m_axis_tuser) + 3'd1), "digest words out of order")

	// an edge seen in reset leaves the output empty
	`SHAMH_ASSERT_ALWAYS(a_rst_quiet, !arst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind sha256_message_hasher shamh_checker u_shamh_checker (.*);

`default_nettype wire
